/* src/uuidsha_pkg.sv */
// Package for the MAC-to-UUID (version 5, SHA-1) unit.
// Holds the message and hash constants, the control word type and the microprogram.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps

package uuidsha_pkg;

    // Step addresses of the microprogram.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_R0   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_R1   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_R2   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_R3   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FIN  = 3'd5;

    // Hold conditions: while true, the sequencer stays on the current step.
    localparam logic [1:0] HOLD_NONE     = 2'd0;
    localparam logic [1:0] HOLD_NO_REQ   = 2'd1;
    localparam logic [1:0] HOLD_LOOP     = 2'd2;
    localparam logic [1:0] HOLD_OUT_FULL = 2'd3;

    // Round groups of SHA-1, twenty rounds each.
    localparam logic [1:0] GRP_CH   = 2'd0;
    localparam logic [1:0] GRP_PAR1 = 2'd1;
    localparam logic [1:0] GRP_MAJ  = 2'd2;
    localparam logic [1:0] GRP_PAR3 = 2'd3;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] LAST_ROUND = 5'd19;

    // Round constants.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Initial hash value.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // Namespace 526480f8-c99b-4be5-a655-58ed5f5d6084 as big-endian words.
    localparam logic [31:0] NS0 = 32'h526480F8;
    localparam logic [31:0] NS1 = 32'hC99B4BE5;
    localparam logic [31:0] NS2 = 32'hA65558ED;
    localparam logic [31:0] NS3 = 32'h5F5D6084;

    // Padding: marker byte after the MAC and the 176-bit message length.
    localparam logic [15:0] PAD_MARK = 16'h8000;
    localparam logic [31:0] MSG_BITS = 32'd176;

    // Version and variant fields of the UUID.
    localparam logic [3:0] UUID_VERSION = 4'h5;
    localparam logic [1:0] UUID_VARIANT = 2'b10;

    // One microprogram word.
    typedef struct packed {
        logic              load;
        logic              round;
        logic [1:0]        grp;
        logic              finish;
        logic [1:0]        hold;
        logic [STEP_W-1:0] next;
    } uword_t;

    // Qualified datapath controls issued by the sequencer each cycle.
    typedef struct packed {
        logic       load_en;
        logic       round_en;
        logic [1:0] grp;
        logic       finish_en;
    } dp_ctl_t;

    // The microprogram: wait for a request, four round groups, then deliver.
    function automatic uword_t prog_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{load: 1'b0, round: 1'b0, grp: GRP_CH, finish: 1'b0,
              hold: HOLD_NONE, next: STEP_IDLE};
        unique case (step)
            STEP_IDLE:
            begin
                w.load = 1'b1;
                w.hold = HOLD_NO_REQ;
                w.next = STEP_R0;
            end
            STEP_R0:
            begin
                w.round = 1'b1;
                w.grp   = GRP_CH;
                w.hold  = HOLD_LOOP;
                w.next  = STEP_R1;
            end
            STEP_R1:
            begin
                w.round = 1'b1;
                w.grp   = GRP_PAR1;
                w.hold  = HOLD_LOOP;
                w.next  = STEP_R2;
            end
            STEP_R2:
            begin
                w.round = 1'b1;
                w.grp   = GRP_MAJ;
                w.hold  = HOLD_LOOP;
                w.next  = STEP_R3;
            end
            STEP_R3:
            begin
                w.round = 1'b1;
                w.grp   = GRP_PAR3;
                w.hold  = HOLD_LOOP;
                w.next  = STEP_FIN;
            end
            STEP_FIN:
            begin
                w.finish = 1'b1;
                w.hold   = HOLD_OUT_FULL;
                w.next   = STEP_IDLE;
            end
            default:
            begin
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/uuidsha_seq.sv */
// Microcode sequencer of the MAC-to-UUID unit: step counter, program ROM and loop counter.
// Depends on uuidsha_pkg for the control word, step codes and hold codes.
`timescale 1ns / 1ps

module uuidsha_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 out_full,
    output uuidsha_pkg::dp_ctl_t ctl,
    output logic                 idle
);
    import uuidsha_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    uword_t            word;
    logic              hold_now;

    // Fetch the control word of the current step.
    assign word = prog_rom(pc_reg);

    // Evaluate the hold condition of this step.
    always_comb
    begin
        unique case (word.hold)
            HOLD_NONE:     hold_now = 1'b0;
            HOLD_NO_REQ:   hold_now = !req_valid;
            HOLD_LOOP:     hold_now = (cnt_reg != LAST_ROUND);
            HOLD_OUT_FULL: hold_now = out_full;
            default:       hold_now = 1'b0;
        endcase
    end

    // Next step and round counter within a group.
    always_comb
    begin
        pc_next  = hold_now ? pc_reg : word.next;
        cnt_next = (word.round && hold_now) ? cnt_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= STEP_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    // Qualified controls for the datapath.
    assign ctl.load_en   = word.load && req_valid;
    assign ctl.round_en  = word.round;
    assign ctl.grp       = word.grp;
    assign ctl.finish_en = word.finish && !out_full;
    assign idle          = word.load;

    // The round counter only runs inside a round group.
    a_cnt_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> word.round)
        else $error("round counter nonzero outside a round step");

    // A load starts the first round group from round zero.
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_en |=> (pc_reg == STEP_R0 && cnt_reg == '0))
        else $error("load did not enter the first round group");

    // The finish step is entered only from the last round group.
    a_fin_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_FIN && $past(pc_reg) != STEP_FIN) |-> ($past(pc_reg) == STEP_R3))
        else $error("finish step entered out of order");

endmodule

/* src/uuidsha_dp.sv */
// SHA-1 datapath of the MAC-to-UUID unit: message schedule window, working registers,
// one round per cycle, and the final digest add with version and variant fields.
// Depends on uuidsha_pkg for constants and the control struct.
`timescale 1ns / 1ps

module uuidsha_dp (
    input  logic                 clk,
    input  uuidsha_pkg::dp_ctl_t ctl,
    input  logic [47:0]          mac_address,
    output logic [63:0]          uuid_upper,
    output logic [63:0]          uuid_lower
);
    import uuidsha_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] c_reg;
    logic [31:0] d_reg;
    logic [31:0] e_reg;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] w_new;
    logic [31:0] tmp;
    logic [31:0] h0;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [63:0] up_raw;
    logic [63:0] lo_raw;

    // Round function and constant of the current group.
    always_comb
    begin
        unique case (ctl.grp)
            GRP_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K0;
            end
            GRP_PAR1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K1;
            end
            GRP_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K3;
            end
        endcase
    end

    // Next schedule word and the new value of a.
    always_comb
    begin
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        tmp   = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
    end

    // Working registers and schedule window; w_reg[0] is the word of the current round.
    always_ff @(posedge clk)
    begin
        if (ctl.load_en)
        begin
            a_reg     <= IV0;
            b_reg     <= IV1;
            c_reg     <= IV2;
            d_reg     <= IV3;
            e_reg     <= IV4;
            w_reg[0]  <= NS0;
            w_reg[1]  <= NS1;
            w_reg[2]  <= NS2;
            w_reg[3]  <= NS3;
            w_reg[4]  <= mac_address[47:16];
            w_reg[5]  <= {mac_address[15:0], PAD_MARK};
            for (int i = 6; i < 15; i++)
            begin
                w_reg[i] <= '0;
            end
            w_reg[15] <= MSG_BITS;
        end
        else if (ctl.round_en)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    // Digest add and UUID field insertion.
    always_comb
    begin
        h0     = IV0 + a_reg;
        h1     = IV1 + b_reg;
        h2     = IV2 + c_reg;
        h3     = IV3 + d_reg;
        up_raw = {h0, h1};
        lo_raw = {h2, h3};
        uuid_upper = {up_raw[63:16], UUID_VERSION, up_raw[11:0]};
        uuid_lower = {UUID_VARIANT, lo_raw[61:0]};
    end

endmodule

/* src/uuid_from_mac_sha1_unit.sv */
// Use of the unit:
// The input channel (in_valid, in_stall, mac_address) carries one request: a 48-bit MAC
// address. The output channel (out_valid, out_stall, uuid_upper, uuid_lower) returns the
// version 5 SHA-1 UUID for that address, byte 0 in uuid_upper[63:56].
// A request is taken only while the sequencer sits on its idle step; in_stall is high
// otherwise. After the request, the single SHA-1 round unit runs 80 rounds, one per cycle,
// and a finish step adds the initial value and writes the output register. The result is
// shown once the finish step has written it; then the sequencer returns to its idle step,
// where the next request can be taken. A request is thus not taken before the previous
// one has passed the 80 rounds of the shared round unit and the load and finish steps.
// A finished result waits in the output register while the next request is processed.
// If the receiver still stalls when the next result is ready, the finish step holds and
// no further request is accepted until the output register is free.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops out_valid.
// Depends on uuidsha_pkg, uuidsha_seq and uuidsha_dp.
`timescale 1ns / 1ps

module uuid_from_mac_sha1_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] mac_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] uuid_upper,
    output logic [63:0] uuid_lower
);
    import uuidsha_pkg::*;

    dp_ctl_t     ctl;
    logic        idle;
    logic        out_full;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] upper_reg;
    logic [63:0] lower_reg;
    logic [63:0] dp_upper;
    logic [63:0] dp_lower;

    // The output register counts as full only if its result is not taken this cycle.
    assign out_full = out_valid_reg && out_stall;

    uuidsha_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .out_full  (out_full),
        .ctl       (ctl),
        .idle      (idle)
    );

    uuidsha_dp u_dp (
        .clk         (clk),
        .ctl         (ctl),
        .mac_address (mac_address),
        .uuid_upper  (dp_upper),
        .uuid_lower  (dp_lower)
    );

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (ctl.finish_en)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (ctl.finish_en)
        begin
            upper_reg <= dp_upper;
            lower_reg <= dp_lower;
        end
    end

    assign in_stall   = !idle;
    assign out_valid  = out_valid_reg;
    assign uuid_upper = upper_reg;
    assign uuid_lower = lower_reg;

    // An accepted request makes the unit busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but unit not busy");

    // A finish always presents a result on the next cycle.
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish_en |=> out_valid)
        else $error("finished result not presented");

    // A finish never overwrites a result that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish_en |-> !(out_valid_reg && out_stall))
        else $error("finish overwrote a pending result");

endmodule

/* tb/uuid_sha1_checker.sv */
// Checker for uuid_from_mac_sha1_unit: watches both channels, derives the expected UUID for
// every accepted request with its own SHA-1 and compares each delivered result in order.
// Depends on uuidsha_pkg for the namespace, padding, hash and UUID field constants.
`timescale 1ns / 1ps

module uuid_sha1_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [47:0] mac_address,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] uuid_upper,
    input  logic [63:0] uuid_lower,
    output int          fail_count,
    output int          pending,
    output int          requests_seen,
    output int          uuids_checked
);
    import uuidsha_pkg::*;

    typedef struct {
        logic [47:0] mac;
        logic [63:0] upper;
        logic [63:0] lower;
    } uuid_rec_t;

    uuid_rec_t expected_uuids[$];

    // Version 5 UUID of one MAC address: one SHA-1 compression of the padded message.
    function automatic uuid_rec_t derive_uuid(input logic [47:0] mac);
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        uuid_rec_t   rec;
        int          i;
        w[0]  = NS0;
        w[1]  = NS1;
        w[2]  = NS2;
        w[3]  = NS3;
        w[4]  = mac[47:16];
        w[5]  = {mac[15:0], PAD_MARK};
        for (i = 6; i < 15; i++)
        begin
            w[i] = 32'h0;
        end
        w[15] = MSG_BITS;
        // Message schedule, each word rotated left by one.
        for (i = 16; i < 80; i++)
        begin
            t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = IV0;
        b = IV1;
        c = IV2;
        d = IV3;
        e = IV4;
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        rec.mac   = mac;
        rec.upper = {IV0 + a, IV1 + b};
        rec.lower = {IV2 + c, IV3 + d};
        // Version nibble in byte 6, variant bits at the top of byte 8.
        rec.upper[15:12] = UUID_VERSION;
        rec.lower[63:62] = UUID_VARIANT;
        return rec;
    endfunction

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        requests_seen = 0;
        uuids_checked = 0;
    end

    // Sample both handshakes at each edge; requests queue an expectation, results consume one.
    always @(posedge clk)
    begin
        uuid_rec_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_uuids.push_back(derive_uuid(mac_address));
                requests_seen++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_uuids.size() == 0)
                begin
                    $display("%0t uuid_checker: unexpected result, expected none, got %h_%h",
                             $time, uuid_upper, uuid_lower);
                    fail_count++;
                end
                else
                begin
                    want = expected_uuids.pop_front();
                    uuids_checked++;
                    if (uuid_upper !== want.upper)
                    begin
                        $display("%0t uuid_checker: mac %h uuid_upper expected %h, got %h",
                                 $time, want.mac, want.upper, uuid_upper);
                        fail_count++;
                    end
                    if (uuid_lower !== want.lower)
                    begin
                        $display("%0t uuid_checker: mac %h uuid_lower expected %h, got %h",
                                 $time, want.mac, want.lower, uuid_lower);
                        fail_count++;
                    end
                end
            end
            pending <= expected_uuids.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Top of the uuid_from_mac_sha1_unit testbench: clock, reset, request stimulus, receiver
// stalls, watchdog and verdict. Depends on uuidsha_pkg, the unit and uuid_sha1_checker.
`timescale 1ns / 1ps

module tb_top;

    // The longest quiet stretch of a correct run is the long receiver hold plus a sender gap
    // and a request, so this leaves several times the margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 600;
    localparam int RANDOM_ITEMS   = 500;
    localparam int DRAIN_CYCLES   = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [47:0] mac_address;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] uuid_upper;
    logic [63:0] uuid_lower;

    int fail_count;
    int pending;
    int requests_seen;
    int uuids_checked;
    int sent_count;
    int idle_cycles;
    bit long_hold_req;

    uuid_from_mac_sha1_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mac_address (mac_address),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .uuid_upper  (uuid_upper),
        .uuid_lower  (uuid_lower)
    );

    uuid_sha1_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mac_address   (mac_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .uuid_upper    (uuid_upper),
        .uuid_lower    (uuid_lower),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .uuids_checked (uuids_checked)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 5);
        else if (r < 97)
            return $urandom_range(6, 90);
        else
            return $urandom_range(91, long_max);
    endfunction

    // Random MAC: mostly uniform, some with extreme bytes, some sparse.
    function automatic logic [47:0] random_mac();
        logic [47:0] mac;
        int          r;
        int          i;
        r   = $urandom_range(0, 99);
        mac = 48'({$urandom, $urandom});
        if (r >= 80 && r < 90)
        begin
            for (i = 0; i < 6; i++)
            begin
                case ($urandom_range(0, 2))
                    0: mac[8*i +: 8] = 8'h00;
                    1: mac[8*i +: 8] = 8'hFF;
                    default: mac[8*i +: 8] = mac[8*i +: 8];
                endcase
            end
        end
        else if (r >= 90)
        begin
            mac = 48'h1 << $urandom_range(0, 47);
            if ($urandom_range(0, 1) == 1)
                mac = ~mac;
        end
        return mac;
    endfunction

    // Offer one request and hold it until the unit takes it.
    task automatic send_request(input logic [47:0] mac);
        in_valid    <= 1'b1;
        mac_address <= mac;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // Drop valid for a number of cycles; the address bus carries junk meanwhile.
    task automatic sender_gap(input int cycles);
        if (cycles > 0)
        begin
            in_valid    <= 1'b0;
            mac_address <= 48'({$urandom, $urandom});
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Wait with valid low until every outstanding request has returned its UUID.
    task automatic drain_outstanding();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Receiver: random stall bursts, occasional long runs without stalls, one long hold.
    initial
    begin : receiver_side
        int run;
        int hold;
        out_stall <= 1'b0;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    run = $urandom_range(150, 400);
                else
                    run = $urandom_range(1, 40);
                out_stall <= 1'b0;
                repeat (run) @(posedge clk);
                hold = 1 + pick_gap(200);
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Watchdog: give up when nothing is accepted on either channel for too long.
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t tb_top: watchdog expired with %0d results outstanding", $time, pending);
        $display("tb_top: done, errors");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [47:0] directed_macs [$];
        int          no_gap_left;
        int          i;
        sent_count    = 0;
        long_hold_req = 1'b0;
        no_gap_left   = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        mac_address  <= 48'h0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, byte and word boundaries of the message block.
        directed_macs = {48'h000000000000, 48'hFFFFFFFFFFFF, 48'h800000000000,
                         48'h000000000001, 48'hAAAAAAAAAAAA, 48'h555555555555,
                         48'hFF0000000000, 48'h0000000000FF, 48'h0000FFFF0000,
                         48'hFFFFFFFF0000, 48'h00000000FFFF, 48'h000000010000,
                         48'h000000008000, 48'h001122334455, 48'h020000000000,
                         48'h010000000000, 48'hFEDCBA987654, 48'h7FFFFFFFFFFF};
        foreach (directed_macs[j])
        begin
            send_request(directed_macs[j]);
            sender_gap(j % 3);
        end
        drain_outstanding();

        // Random requests with a long receiver hold and a full drain along the way.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 150)
            begin
                long_hold_req = 1'b1;
                no_gap_left   = 10;
            end
            if (i == 300)
                drain_outstanding();
            send_request(random_mac());
            if (no_gap_left > 0)
                no_gap_left--;
            else if (i >= 350 && i < 400)
                sender_gap(0);
            else
                sender_gap(pick_gap(300));
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $display("%0t tb_top: %0d expected UUIDs never arrived", $time, pending);
        $display("tb_top: %0d requests sent, %0d accepted, %0d UUIDs compared",
                 sent_count, requests_seen, uuids_checked);
        $display("tb_top: covered extremes, walking bits, a long receiver hold and a full drain");
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* uuid_from_mac_sha1_unit.f */
src/uuidsha_pkg.sv
src/uuidsha_seq.sv
src/uuidsha_dp.sv
src/uuid_from_mac_sha1_unit.sv
tb/uuid_sha1_checker.sv
tb/tb_top.sv
